// File: rtl/mtep_pkg.sv
// shared types and constants of the midi track event parser
package mtep_pkg;

  localparam logic [7:0] META_STATUS = 8'hFF;
  localparam logic [7:0] TRACK_NAME_TYPE = 8'h03;

  typedef enum logic [2:0] {
    KIND_CHANNEL     = 3'd0,
    KIND_META_HEADER = 3'd1,
    KIND_META_DATA   = 3'd2,
    KIND_UNKNOWN     = 3'd3,
    KIND_TRACK_END   = 3'd4,
    KIND_TRUNCATED   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_DATA1  = 3'd2,
    PH_DATA2  = 3'd3,
    PH_MTYPE  = 3'd4,
    PH_MLEN   = 3'd5,
    PH_MDATA  = 3'd6,
    PH_SKIP   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_last;
  } item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_last;
    logic       high_bit;
    logic [1:0] chan_bytes;
  } entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] delta_time;
    logic [7:0]  status;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [1:0]  data_count;
    logic [7:0]  meta_type;
    logic [31:0] meta_length;
    logic [7:0]  meta_byte;
    logic        is_track_name;
    logic        meta_last;
    logic        track_end;
  } result_t;

  typedef struct packed {
    logic   empty;
    entry_t entry;
  } front_q_t;

  function automatic logic [1:0] channel_bytes(input logic [7:0] s);
    logic [1:0] n;
    begin
      case (s[7:4])
        4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
        4'hC, 4'hD: n = 2'd1;
        default: n = 2'd0;
      endcase
      return n;
    end
  endfunction

endpackage

// File: rtl/mtep_fifo.sv
// two-entry register queue
module mtep_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/mtep_front.sv
// byte intake: classifies each chunk byte and queues it for the parser
module mtep_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mtep_pkg::item_t     item,
  output logic                full,
  input  logic                q_pop,
  output mtep_pkg::front_q_t  q
);

  mtep_pkg::entry_t entry_in;
  logic [$bits(mtep_pkg::entry_t)-1:0] q_data;
  logic q_empty;

  always_comb begin
    entry_in.data_byte  = item.data_byte;
    entry_in.track_last = item.track_last;
    entry_in.high_bit   = item.data_byte[7];
    entry_in.chan_bytes = mtep_pkg::channel_bytes(item.data_byte);
  end

  mtep_fifo #(
    .WIDTH($bits(mtep_pkg::entry_t))
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry_in),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  assign q = {q_empty, q_data};

endmodule

// File: rtl/mtep_back.sv
// event parser state machine: one queued byte per cycle into the result queue, stalling while it is full
module mtep_back #(
  parameter int LENGTH_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  mtep_pkg::front_q_t  q,
  output logic                q_pop,
  input  logic                out_full,
  output logic                out_push,
  output mtep_pkg::result_t   out_data
);

  mtep_pkg::phase_t        phase, phase_next;
  logic [7:0]              running_status, running_status_next;
  logic [1:0]              running_cls, running_cls_next;
  logic [31:0]             delta_accum, delta_accum_next;
  logic [7:0]              event_status, event_status_next;
  logic [1:0]              event_cls, event_cls_next;
  logic [7:0]              held_data, held_data_next;
  logic [7:0]              held_meta_type, held_meta_type_next;
  logic [LENGTH_WIDTH-1:0] meta_len_accum, meta_len_accum_next;
  logic [LENGTH_WIDTH-1:0] meta_remaining, meta_remaining_next;

  logic step;
  logic have;

  assign step     = !q.empty && !out_full;
  assign q_pop    = step;
  assign out_push = step && have;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mtep_pkg::PH_DELTA;
      running_status <= 8'd0;
      running_cls    <= 2'd0;
      delta_accum    <= 32'd0;
      event_status   <= 8'd0;
      event_cls      <= 2'd0;
      held_data      <= 8'd0;
      held_meta_type <= 8'd0;
      meta_len_accum <= '0;
      meta_remaining <= '0;
    end else if (step) begin
      phase          <= phase_next;
      running_status <= running_status_next;
      running_cls    <= running_cls_next;
      delta_accum    <= delta_accum_next;
      event_status   <= event_status_next;
      event_cls      <= event_cls_next;
      held_data      <= held_data_next;
      held_meta_type <= held_meta_type_next;
      meta_len_accum <= meta_len_accum_next;
      meta_remaining <= meta_remaining_next;
    end
  end

  always_comb begin
    mtep_pkg::phase_t        ph;
    logic [7:0]              b;
    logic                    hi;
    logic [7:0]              es;
    logic [1:0]              ncls;
    logic [LENGTH_WIDTH-1:0] len_new;
    logic [LENGTH_WIDTH-1:0] rem_new;
    logic                    pending;

    b       = q.entry.data_byte;
    hi      = q.entry.high_bit;
    es      = 8'd0;
    ncls    = 2'd0;
    len_new = '0;
    rem_new = '0;
    pending = 1'b0;
    have    = 1'b0;

    phase_next          = phase;
    running_status_next = running_status;
    running_cls_next    = running_cls;
    delta_accum_next    = delta_accum;
    event_status_next   = event_status;
    event_cls_next      = event_cls;
    held_data_next      = held_data;
    held_meta_type_next = held_meta_type;
    meta_len_accum_next = meta_len_accum;
    meta_remaining_next = meta_remaining;
    out_data            = '0;

    ph = (phase == mtep_pkg::PH_SKIP && hi) ? mtep_pkg::PH_DELTA : phase;
    phase_next = ph;

    unique case (ph)
      mtep_pkg::PH_DELTA: begin
        delta_accum_next = {delta_accum[24:0], b[6:0]};
        if (hi) begin
          pending = 1'b1;
        end else begin
          phase_next = mtep_pkg::PH_STATUS;
        end
      end
      mtep_pkg::PH_STATUS: begin
        es   = hi ? b : running_status;
        ncls = hi ? q.entry.chan_bytes : running_cls;
        if (hi) begin
          running_status_next = b;
          running_cls_next    = q.entry.chan_bytes;
        end
        event_status_next = es;
        event_cls_next    = ncls;
        if (es == mtep_pkg::META_STATUS) begin
          if (hi) begin
            phase_next = mtep_pkg::PH_MTYPE;
          end else begin
            held_meta_type_next = b;
            meta_len_accum_next = '0;
            phase_next          = mtep_pkg::PH_MLEN;
          end
        end else if (ncls == 2'd0) begin
          out_data.kind       = mtep_pkg::KIND_UNKNOWN;
          out_data.delta_time = delta_accum;
          out_data.status     = es;
          delta_accum_next    = 32'd0;
          phase_next          = mtep_pkg::PH_SKIP;
          have                = 1'b1;
        end else if (hi) begin
          phase_next = mtep_pkg::PH_DATA1;
        end else if (ncls == 2'd1) begin
          out_data.kind       = mtep_pkg::KIND_CHANNEL;
          out_data.delta_time = delta_accum;
          out_data.status     = es;
          out_data.data_first = b;
          out_data.data_count = 2'd1;
          delta_accum_next    = 32'd0;
          phase_next          = mtep_pkg::PH_DELTA;
          have                = 1'b1;
        end else begin
          held_data_next = b;
          phase_next     = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA1: begin
        if (event_cls == 2'd1) begin
          out_data.kind       = mtep_pkg::KIND_CHANNEL;
          out_data.delta_time = delta_accum;
          out_data.status     = event_status;
          out_data.data_first = b;
          out_data.data_count = 2'd1;
          delta_accum_next    = 32'd0;
          phase_next          = mtep_pkg::PH_DELTA;
          have                = 1'b1;
        end else begin
          held_data_next = b;
          phase_next     = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA2: begin
        out_data.kind        = mtep_pkg::KIND_CHANNEL;
        out_data.delta_time  = delta_accum;
        out_data.status      = event_status;
        out_data.data_first  = held_data;
        out_data.data_second = b;
        out_data.data_count  = 2'd2;
        delta_accum_next     = 32'd0;
        phase_next           = mtep_pkg::PH_DELTA;
        have                 = 1'b1;
      end
      mtep_pkg::PH_MTYPE: begin
        held_meta_type_next = b;
        meta_len_accum_next = '0;
        phase_next          = mtep_pkg::PH_MLEN;
      end
      mtep_pkg::PH_MLEN: begin
        len_new = {meta_len_accum[LENGTH_WIDTH-8:0], b[6:0]};
        meta_len_accum_next = len_new;
        if (!hi) begin
          out_data.kind          = mtep_pkg::KIND_META_HEADER;
          out_data.delta_time    = delta_accum;
          out_data.status        = mtep_pkg::META_STATUS;
          out_data.meta_type     = held_meta_type;
          out_data.meta_length   = 32'(len_new);
          out_data.is_track_name = (held_meta_type == mtep_pkg::TRACK_NAME_TYPE);
          out_data.meta_last     = (len_new == '0);
          have                   = 1'b1;
          delta_accum_next       = 32'd0;
          meta_remaining_next    = len_new;
          phase_next = (len_new != '0) ? mtep_pkg::PH_MDATA : mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_MDATA: begin
        rem_new = meta_remaining - LENGTH_WIDTH'(1);
        meta_remaining_next    = rem_new;
        out_data.kind          = mtep_pkg::KIND_META_DATA;
        out_data.status        = mtep_pkg::META_STATUS;
        out_data.meta_type     = held_meta_type;
        out_data.meta_length   = 32'(meta_len_accum);
        out_data.meta_byte     = b;
        out_data.is_track_name = (held_meta_type == mtep_pkg::TRACK_NAME_TYPE);
        out_data.meta_last     = (rem_new == '0);
        have                   = 1'b1;
        if (rem_new == '0) begin
          phase_next = mtep_pkg::PH_DELTA;
        end
      end
      default: begin
      end
    endcase

    if (phase_next != mtep_pkg::PH_DELTA && phase_next != mtep_pkg::PH_SKIP) begin
      pending = 1'b1;
    end

    // end of chunk: report and return to reset state
    if (q.entry.track_last) begin
      if (pending) begin
        out_data            = '0;
        out_data.kind       = mtep_pkg::KIND_TRUNCATED;
        out_data.delta_time = delta_accum_next;
        if (phase_next != mtep_pkg::PH_DELTA && phase_next != mtep_pkg::PH_STATUS) begin
          out_data.status = event_status_next;
        end
      end else if (!have) begin
        out_data.kind = mtep_pkg::KIND_TRACK_END;
      end
      out_data.track_end  = 1'b1;
      have                = 1'b1;
      phase_next          = mtep_pkg::PH_DELTA;
      running_status_next = 8'd0;
      running_cls_next    = 2'd0;
      delta_accum_next    = 32'd0;
      event_status_next   = 8'd0;
      event_cls_next      = 2'd0;
      held_data_next      = 8'd0;
      held_meta_type_next = 8'd0;
      meta_len_accum_next = '0;
      meta_remaining_next = '0;
    end
  end

endmodule

// File: rtl/midi_track_event_parser.sv
// midi track event parser top level: byte intake, parser, result queue
// a byte is registered in the intake queue and its result in the result queue before the result can be popped
// throughput: one byte per cycle while the result queue is not full, one parser step per queued byte
// two-entry queues on intake and results keep full and empty free of combinational paths
// reset: synchronous rst empties both queues and returns the parser to awaiting a delta
module midi_track_event_parser #(
  parameter int LENGTH_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mtep_pkg::item_t   item,
  output logic              full,
  input  logic              pop,
  output mtep_pkg::result_t result,
  output logic              empty
);

  mtep_pkg::front_q_t front_q;
  logic               q_pop;
  logic               out_full;
  logic               out_push;
  mtep_pkg::result_t  out_data;
  logic [$bits(mtep_pkg::result_t)-1:0] res_bits;

  mtep_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .full  (full),
    .q_pop (q_pop),
    .q     (front_q)
  );

  mtep_back #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q        (front_q),
    .q_pop    (q_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_data (out_data)
  );

  mtep_fifo #(
    .WIDTH($bits(mtep_pkg::result_t))
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_data),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  assign result = mtep_pkg::result_t'(res_bits);

endmodule

// File: sim/midi_track_event_parser_chk.sv
// checker for the midi track event parser: predicts results per byte and compares them
`timescale 1ns / 1ps

module midi_track_event_parser_chk (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mtep_pkg::item_t   item,
  input  logic              full,
  input  logic              pop,
  input  mtep_pkg::result_t result,
  input  logic              empty,
  output int                errors,
  output int                waiting,
  output int                results_seen
);

  mtep_pkg::phase_t phase;
  logic [7:0]  run_status;
  logic [7:0]  ev_status;
  logic [7:0]  held_byte;
  logic [7:0]  mtype;
  logic [31:0] delta_acc;
  logic [31:0] mlen;
  logic [31:0] mleft;

  mtep_pkg::result_t expected_events[$];

  function automatic logic [1:0] data_bytes_of(input logic [7:0] s);
    if (!s[7] || s[7:4] == 4'hF) return 2'd0;
    if (s[6:5] == 2'b10) return 2'd1;
    return 2'd2;
  endfunction

  task automatic reset_parser();
    phase = mtep_pkg::PH_DELTA;
    run_status = '0;
    ev_status = '0;
    held_byte = '0;
    mtype = '0;
    delta_acc = '0;
    mlen = '0;
    mleft = '0;
  endtask

  task automatic emit_channel(inout mtep_pkg::result_t r, input logic [7:0] d1,
                              input logic [7:0] d2, input logic [1:0] n);
    r.kind = mtep_pkg::KIND_CHANNEL;
    r.delta_time = delta_acc;
    r.status = ev_status;
    r.data_first = d1;
    r.data_second = d2;
    r.data_count = n;
    delta_acc = '0;
    phase = mtep_pkg::PH_DELTA;
  endtask

  task automatic open_meta(input logic [7:0] t);
    mtype = t;
    mlen = '0;
    phase = mtep_pkg::PH_MLEN;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last, output logic have,
                            output mtep_pkg::result_t r);
    logic       open_event;
    logic [1:0] n;
    r = '0;
    have = 1'b0;
    open_event = 1'b0;
    if (phase == mtep_pkg::PH_SKIP && b[7]) phase = mtep_pkg::PH_DELTA;
    case (phase)
      mtep_pkg::PH_DELTA: begin
        delta_acc = {delta_acc[24:0], b[6:0]};
        if (b[7]) open_event = 1'b1;
        else phase = mtep_pkg::PH_STATUS;
      end
      mtep_pkg::PH_STATUS: begin
        if (b[7]) begin
          ev_status = b;
          run_status = b;
        end else begin
          ev_status = run_status;
        end
        n = data_bytes_of(ev_status);
        if (ev_status == mtep_pkg::META_STATUS) begin
          if (b[7]) phase = mtep_pkg::PH_MTYPE;
          else open_meta(b);
        end else if (n == 2'd0) begin
          r.kind = mtep_pkg::KIND_UNKNOWN;
          r.delta_time = delta_acc;
          r.status = ev_status;
          delta_acc = '0;
          phase = mtep_pkg::PH_SKIP;
          have = 1'b1;
        end else if (b[7]) begin
          phase = mtep_pkg::PH_DATA1;
        end else if (n == 2'd1) begin
          emit_channel(r, b, 8'h00, 2'd1);
          have = 1'b1;
        end else begin
          held_byte = b;
          phase = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA1: begin
        if (data_bytes_of(ev_status) == 2'd1) begin
          emit_channel(r, b, 8'h00, 2'd1);
          have = 1'b1;
        end else begin
          held_byte = b;
          phase = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA2: begin
        emit_channel(r, held_byte, b, 2'd2);
        have = 1'b1;
      end
      mtep_pkg::PH_MTYPE: begin
        open_meta(b);
      end
      mtep_pkg::PH_MLEN: begin
        mlen = {mlen[24:0], b[6:0]};
        if (!b[7]) begin
          r.kind = mtep_pkg::KIND_META_HEADER;
          r.delta_time = delta_acc;
          r.status = mtep_pkg::META_STATUS;
          r.meta_type = mtype;
          r.meta_length = mlen;
          r.is_track_name = (mtype == mtep_pkg::TRACK_NAME_TYPE);
          r.meta_last = (mlen == '0);
          have = 1'b1;
          delta_acc = '0;
          mleft = mlen;
          if (mleft != '0) phase = mtep_pkg::PH_MDATA;
          else phase = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_MDATA: begin
        mleft = mleft - 32'd1;
        r.kind = mtep_pkg::KIND_META_DATA;
        r.status = mtep_pkg::META_STATUS;
        r.meta_type = mtype;
        r.meta_length = mlen;
        r.meta_byte = b;
        r.is_track_name = (mtype == mtep_pkg::TRACK_NAME_TYPE);
        r.meta_last = (mleft == '0);
        have = 1'b1;
        if (mleft == '0) phase = mtep_pkg::PH_DELTA;
      end
      default: begin
      end
    endcase
    if (phase != mtep_pkg::PH_DELTA && phase != mtep_pkg::PH_SKIP) open_event = 1'b1;
    if (last) begin
      if (open_event) begin
        r = '0;
        r.kind = mtep_pkg::KIND_TRUNCATED;
        r.delta_time = delta_acc;
        if (phase != mtep_pkg::PH_DELTA && phase != mtep_pkg::PH_STATUS) r.status = ev_status;
      end else if (!have) begin
        r.kind = mtep_pkg::KIND_TRACK_END;
      end
      r.track_end = 1'b1;
      have = 1'b1;
      reset_parser();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[chk] %0t result %0d: %s", $time, results_seen, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic compare_result(input mtep_pkg::result_t want);
    check_field("kind", 32'(result.kind), 32'(want.kind));
    check_field("delta_time", result.delta_time, want.delta_time);
    check_field("status", 32'(result.status), 32'(want.status));
    check_field("data_first", 32'(result.data_first), 32'(want.data_first));
    check_field("data_second", 32'(result.data_second), 32'(want.data_second));
    check_field("data_count", 32'(result.data_count), 32'(want.data_count));
    check_field("meta_type", 32'(result.meta_type), 32'(want.meta_type));
    check_field("meta_length", result.meta_length, want.meta_length);
    check_field("meta_byte", 32'(result.meta_byte), 32'(want.meta_byte));
    check_field("is_track_name", 32'(result.is_track_name), 32'(want.is_track_name));
    check_field("meta_last", 32'(result.meta_last), 32'(want.meta_last));
    check_field("track_end", 32'(result.track_end), 32'(want.track_end));
  endtask

  always @(posedge clk) begin : watch
    logic              have;
    mtep_pkg::result_t want;
    if (rst) begin
      reset_parser();
      expected_events.delete();
      waiting = 0;
    end else begin
      if (push && !full) begin
        parse_byte(item.data_byte, item.track_last, have, want);
        if (have) expected_events.insert(expected_events.size(), want);
      end
      if (pop && !empty) begin
        results_seen++;
        if (expected_events.size() == 0) report_mismatch("transaction with nothing expected");
        else compare_result(expected_events.pop_front());
      end
      waiting = expected_events.size();
    end
  end

endmodule

// File: sim/midi_track_event_parser_tb.sv
// testbench top for the midi track event parser: byte stimulus, result draining, verdict
`timescale 1ns / 1ps

module midi_track_event_parser_tb;

  localparam int RANDOM_BYTES = 1800;
  localparam int HOLD_CYCLES = 300;
  localparam int N_DIRECTED = 26;
  // bit 8 marks the last byte of a track
  localparam logic [8:0] DIRECTED_BYTES [N_DIRECTED] = '{
    9'h000, 9'h03C, 9'h105,
    9'h000, 9'h090, 9'h03C, 9'h07F,
    9'h000, 9'h03C, 9'h000,
    9'h081, 9'h000, 9'h0C5, 9'h07F,
    9'h000, 9'h010,
    9'h000, 9'h0FF, 9'h003, 9'h001, 9'h041,
    9'h000, 9'h005, 9'h100,
    9'h000, 9'h1E0
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              push;
  mtep_pkg::item_t   item;
  logic              full;
  logic              pop;
  mtep_pkg::result_t result;
  logic              empty;

  int errors;
  int waiting;
  int results_seen;
  int sent;
  int tracks;
  bit calm;

  mtep_pkg::item_t stim_q[$];
  logic [7:0]      gen_run;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  midi_track_event_parser dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .pop    (pop),
    .result (result),
    .empty  (empty)
  );

  midi_track_event_parser_chk chk (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .item         (item),
    .full         (full),
    .pop          (pop),
    .result       (result),
    .empty        (empty),
    .errors       (errors),
    .waiting      (waiting),
    .results_seen (results_seen)
  );

  task automatic put_byte(input logic [7:0] b);
    stim_q.insert(stim_q.size(), {b, 1'b0});
  endtask

  task automatic mark_last();
    stim_q[stim_q.size() - 1].track_last = 1'b1;
  endtask

  task automatic put_vlq(input logic [63:0] v, input int n);
    int         i;
    logic [7:0] b;
    for (i = n - 1; i >= 0; i--) begin
      b[6:0] = v[7 * i +: 7];
      b[7] = (i != 0);
      put_byte(b);
    end
  endtask

  function automatic logic [7:0] data_val();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(127));
  endfunction

  function automatic logic [7:0] meta_type_val();
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) return mtep_pkg::TRACK_NAME_TYPE;
    if (pick == 3) return 8'h2F;
    return 8'($urandom_range(255));
  endfunction

  task automatic put_delta();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) put_vlq(64'($urandom_range(127)), 1);
    else if (pick < 88) put_vlq(64'($urandom_range(16383)), 2);
    else if (pick < 96) put_vlq(64'($urandom), 4);
    else put_vlq({$urandom, $urandom}, 5);
  endtask

  task automatic put_meta_body(input logic [7:0] t);
    int len;
    len = $urandom_range(5);
    put_byte(t);
    if ($urandom_range(9) == 0) put_vlq(64'(len), 2);
    else put_vlq(64'(len), 1);
    repeat (len) put_byte(8'($urandom_range(255)));
  endtask

  task automatic put_event();
    int         pick;
    logic [7:0] s;
    put_delta();
    pick = $urandom_range(99);
    if (pick < 35) begin
      s = {4'($urandom_range(8, 14)), 4'($urandom_range(15))};
      gen_run = s;
      put_byte(s);
      put_byte(data_val());
      if (s[6:5] != 2'b10) put_byte(data_val());
    end else if (pick < 60) begin
      if (gen_run == mtep_pkg::META_STATUS) begin
        put_meta_body(8'($urandom_range(127)));
      end else begin
        put_byte(8'($urandom_range(127)));
        if (gen_run[7] && gen_run[7:4] != 4'hF && gen_run[6:5] != 2'b10) put_byte(data_val());
      end
    end else if (pick < 80) begin
      gen_run = mtep_pkg::META_STATUS;
      put_byte(mtep_pkg::META_STATUS);
      put_meta_body(meta_type_val());
    end else if (pick < 90) begin
      s = 8'($urandom_range(240, 254));
      gen_run = s;
      put_byte(s);
      repeat ($urandom_range(3)) put_byte(8'($urandom_range(127)));
      put_byte(8'h80);
    end else begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic put_track();
    int n_events;
    int style;
    int start;
    int keep;
    gen_run = '0;
    n_events = ($urandom_range(9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
    repeat (n_events) put_event();
    style = $urandom_range(99);
    if (style < 55) begin
      mark_last();
    end else if (style < 80) begin
      start = stim_q.size();
      put_event();
      if (stim_q.size() - start >= 2) keep = start + $urandom_range(1, stim_q.size() - start - 1);
      else keep = stim_q.size();
      while (stim_q.size() > keep) void'(stim_q.pop_back());
      mark_last();
    end else if (style < 92) begin
      put_delta();
      put_byte(8'($urandom_range(240, 254)));
      put_byte(8'($urandom_range(127)));
      mark_last();
    end else begin
      put_delta();
      put_byte(mtep_pkg::META_STATUS);
      put_byte(meta_type_val());
      put_vlq({$urandom, $urandom}, $urandom_range(4, 5));
      repeat ($urandom_range(3)) put_byte(8'($urandom_range(255)));
      mark_last();
    end
    tracks++;
  endtask

  initial begin : feed_side
    int i;
    int guard;
    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    calm = 1'b0;
    for (i = 0; i < N_DIRECTED; i++) begin
      stim_q.insert(stim_q.size(), {DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]});
      if (DIRECTED_BYTES[i][8]) tracks++;
    end
    while (stim_q.size() < N_DIRECTED + RANDOM_BYTES) put_track();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < stim_q.size(); i++) begin
      calm = (i >= 900 && i < 1200);
      if (!calm) begin
        while ($urandom_range(99) < 21) begin
          push <= 1'b0;
          @(posedge clk);
        end
      end
      push <= 1'b1;
      item <= stim_q[i];
      @(posedge clk);
      while (full) @(posedge clk);
      sent++;
    end
    push <= 1'b0;
    calm = 1'b0;
    guard = 0;
    @(posedge clk);
    while (waiting != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    $display("covered %0d bytes in %0d tracks, %0d results checked", stim_q.size(), tracks,
             results_seen);
    $display("with a %0d-cycle receiver hold-off and an idle-free stretch", HOLD_CYCLES);
    if (errors == 0 && waiting == 0) begin
      $display("[midi_track_event_parser] OK");
    end else begin
      $display("[midi_track_event_parser] ERROR");
    end
    $finish;
  end

  initial begin : drain_side
    int  hold;
    bit  held;
    pop <= 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sent >= 400) begin
        held = 1'b1;
        pop <= 1'b0;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
      end
      pop <= calm || ($urandom_range(99) >= 21);
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #200000;
    $display("[midi_track_event_parser] ERROR");
    $finish;
  end

endmodule
